[rtl/glmd_pkg.sv]
// shared types and constants for the grid local minimum detector
package glmd_pkg;

  localparam int CFG_BITS    = 11;
  localparam int POS_BITS    = 10;
  localparam int SAMPLE_BITS = 8;
  localparam int RISK_BITS   = 9;
  localparam int TOTAL_BITS  = 29;
  localparam logic [TOTAL_BITS-1:0] TOTAL_MAX = '1;

  // results per accepted sample: cell above, cell to the left, frame corner
  localparam int RUN_MAX   = 3;
  localparam int SLOT_BITS = 2;

  // result queue, in bundles of one sample each; depth is a power of two
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_BITS   = 2;
  localparam int QCNT_BITS   = 3;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0] height;
  } sample_t;

  typedef struct packed {
    logic [POS_BITS-1:0]    row;
    logic [POS_BITS-1:0]    col;
    logic [SAMPLE_BITS-1:0] cell_height;
    logic                   is_low;
    logic [RISK_BITS-1:0]   risk;
    logic [TOTAL_BITS-1:0]  risk_total;
    logic                   last_of_run;
    logic                   frame_done;
  } decision_t;

  typedef struct packed {
    logic [POS_BITS-1:0]    row;
    logic [POS_BITS-1:0]    col;
    logic [SAMPLE_BITS-1:0] cell_height;
    logic                   is_low;
    logic [RISK_BITS-1:0]   risk;
    logic                   frame_done;
  } result_t;

  typedef struct packed {
    logic                         clear;
    logic [SLOT_BITS-1:0]         count;
    result_t [RUN_MAX-1:0]        slot;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t bundle;
  } push_t;

endpackage

[rtl/glmd_stream_if.sv]
// valid/ready stream channel carrying one payload item per request
interface glmd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[rtl/glmd_out_queue.sv]
// result bundle queue, serializer and running risk accumulator
module glmd_out_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  glmd_pkg::push_t       push,
  output logic                  room,
  glmd_stream_if.source         decisions
);

  glmd_pkg::bundle_t                     q_mem [glmd_pkg::QUEUE_DEPTH];
  logic [glmd_pkg::QPTR_BITS-1:0]        wr_ptr;
  logic [glmd_pkg::QPTR_BITS-1:0]        rd_ptr;
  logic [glmd_pkg::QCNT_BITS-1:0]        q_count;
  logic [glmd_pkg::SLOT_BITS-1:0]        slot_idx;
  logic [glmd_pkg::TOTAL_BITS-1:0]       acc;
  logic                                  out_valid;
  glmd_pkg::decision_t                   out_data;

  glmd_pkg::bundle_t                     head;
  glmd_pkg::result_t                     cur;
  logic                                  last;
  logic                                  load;
  logic                                  pop;
  logic [glmd_pkg::TOTAL_BITS-1:0]       base;
  logic [glmd_pkg::TOTAL_BITS:0]         sum;
  logic [glmd_pkg::TOTAL_BITS-1:0]       total;

  assign head  = q_mem[rd_ptr];
  assign cur   = head.slot[slot_idx];
  assign last  = (slot_idx == head.count - glmd_pkg::SLOT_BITS'(1));
  assign load  = (q_count != '0) && (!out_valid || decisions.ready);
  assign pop   = load && last;
  assign room  = (q_count <= glmd_pkg::QCNT_BITS'(glmd_pkg::QUEUE_DEPTH - 2));

  // frame start clears the total ahead of the bundle's first result
  assign base  = (head.clear && slot_idx == '0) ? '0 : acc;
  assign sum   = {1'b0, base} + (glmd_pkg::TOTAL_BITS + 1)'(cur.risk);
  assign total = sum[glmd_pkg::TOTAL_BITS] ? glmd_pkg::TOTAL_MAX
                                           : sum[glmd_pkg::TOTAL_BITS-1:0];

  always_ff @(posedge clk) begin
    if (push.valid) begin
      q_mem[wr_ptr] <= push.bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr    <= '0;
      rd_ptr    <= '0;
      q_count   <= '0;
      slot_idx  <= '0;
      acc       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (push.valid) begin
        wr_ptr <= wr_ptr + glmd_pkg::QPTR_BITS'(1);
      end
      unique case ({push.valid, pop})
        2'b10:   q_count <= q_count + glmd_pkg::QCNT_BITS'(1);
        2'b01:   q_count <= q_count - glmd_pkg::QCNT_BITS'(1);
        default: q_count <= q_count;
      endcase
      if (load) begin
        acc       <= total;
        out_valid <= 1'b1;
        if (last) begin
          slot_idx <= '0;
          rd_ptr   <= rd_ptr + glmd_pkg::QPTR_BITS'(1);
        end else begin
          slot_idx <= slot_idx + glmd_pkg::SLOT_BITS'(1);
        end
      end else if (decisions.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data.row         <= cur.row;
      out_data.col         <= cur.col;
      out_data.cell_height <= cur.cell_height;
      out_data.is_low      <= cur.is_low;
      out_data.risk        <= cur.risk;
      out_data.risk_total  <= total;
      out_data.last_of_run <= last;
      out_data.frame_done  <= cur.frame_done;
    end
  end

  assign decisions.valid   = out_valid;
  assign decisions.payload = out_data;

endmodule

[rtl/grid_local_minimum_detect.sv]
// top level: 4-neighbour strict local minimum detector over a streamed raster
//
// Heights arrive in row-major order, one per request on samples, and the block
// takes one sample every clock while its result queue has room. Each sample
// settles up to three cells: the cell above it (once its lower neighbour is
// in), on the last row the cell to its left, and on the frame's last cell that
// cell itself. Results leave on decisions one per clock while decisions is
// ready, so the last row, which yields two results per sample, drains at half
// rate and back-pressures the input; every other row runs at one sample per
// clock. A sample's first result passes the compare stage register, the
// result queue and the output register onto decisions. The rate is set by
// the line memory, which is read at two columns and written at one each clock,
// and by the single output register. The line memory holds MAX_WIDTH entries
// of the two previous rows; it is not cleared after reset, which is safe since
// a frame never reads a column before writing it. Frame size registers take
// 0 as 1 and clamp at MAX_WIDTH / MAX_HEIGHT; write them only while idle.
module grid_local_minimum_detect #(
  parameter int MAX_WIDTH   = 1024,
  parameter int MAX_HEIGHT  = 1024,
  parameter int HEIGHT_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  glmd_stream_if.sink                       samples,
  glmd_stream_if.source                     decisions,
  input  logic                              cfg_we,
  input  glmd_pkg::reg_index_t              cfg_index,
  input  logic [glmd_pkg::CFG_BITS-1:0]     cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH + 1);
  localparam int RW = $clog2(MAX_HEIGHT + 1);
  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int HB = HEIGHT_BITS;
  localparam int W_RESET = (MAX_WIDTH < 1024) ? MAX_WIDTH : 1024;
  localparam int H_RESET = (MAX_HEIGHT < 1024) ? MAX_HEIGHT : 1024;
  localparam logic [glmd_pkg::SAMPLE_BITS-1:0] IN_MASK =
    glmd_pkg::SAMPLE_BITS'((1 << HEIGHT_BITS) - 1);

  // position flags worked out when the sample is accepted
  typedef struct packed {
    logic first;      // row 0, column 0
    logic r_ge1;
    logic r_ge2;
    logic c_ge1;
    logic c_ge2;
    logic has_right;  // column + 1 inside the frame
    logic last_row;
    logic last_col;
  } pos_flags_t;

  // frame size, clamped at write time
  logic [CW-1:0] frame_w;
  logic [RW-1:0] frame_h;
  logic [CW-1:0] clamp_w;
  logic [RW-1:0] clamp_h;

  // position of the next sample
  logic [CW-1:0] col_count;
  logic [RW-1:0] row_count;

  // accept stage
  logic          accept;
  logic          wrap;
  logic [CW-1:0] cur_c;
  logic [RW-1:0] cur_r;
  logic [CW-1:0] c_next;
  logic [RW-1:0] r_next;
  logic          end_col;
  logic          end_row;
  logic [AW-1:0] addr_a;
  logic [AW-1:0] addr_b;
  pos_flags_t    flags;

  // compare stage
  logic          s1_valid;
  logic [HB-1:0] s1_x;
  logic [RW-1:0] s1_r;
  logic [CW-1:0] s1_c;
  pos_flags_t    s1_f;
  logic          clear_pending;

  // earlier samples of the current row and the row above
  logic [HB-1:0] prev_x;
  logic [HB-1:0] prev_x2;
  logic [HB-1:0] prev_above;

  // line memory: upper half is the row above, lower half the row before it
  logic [2*HB-1:0] line_mem [MAX_WIDTH];
  logic [2*HB-1:0] rd_a;
  logic [2*HB-1:0] rd_b;
  logic [2*HB-1:0] wd_q;
  logic            fwd_a;
  logic            fwd_b;
  logic            mem_we;
  logic [AW-1:0]   mem_wa;
  logic [2*HB-1:0] mem_wd;
  logic [2*HB-1:0] ent_a;
  logic [2*HB-1:0] ent_b;
  logic [HB-1:0]   above_v;
  logic [HB-1:0]   up_v;
  logic [HB-1:0]   right_v;

  logic            above_low;
  logic            left_low;
  logic            corner_low;
  glmd_pkg::push_t push;
  logic            room;

  function automatic glmd_pkg::result_t make_result(
    input logic [glmd_pkg::POS_BITS-1:0] row,
    input logic [glmd_pkg::POS_BITS-1:0] col,
    input logic [HB-1:0]                 h,
    input logic                          low,
    input logic                          done
  );
    glmd_pkg::result_t res;
    res.row         = row;
    res.col         = col;
    res.cell_height = glmd_pkg::SAMPLE_BITS'(h);
    res.is_low      = low;
    res.risk        = low ? glmd_pkg::RISK_BITS'(h) + glmd_pkg::RISK_BITS'(1) : '0;
    res.frame_done  = done;
    return res;
  endfunction

  // size registers: zero acts as one, large values clamp at the maximum
  always_comb begin
    if (cfg_data == '0) begin
      clamp_w = CW'(1);
    end else if (32'(cfg_data) > 32'(MAX_WIDTH)) begin
      clamp_w = CW'(MAX_WIDTH);
    end else begin
      clamp_w = CW'(cfg_data);
    end
    if (cfg_data == '0) begin
      clamp_h = RW'(1);
    end else if (32'(cfg_data) > 32'(MAX_HEIGHT)) begin
      clamp_h = RW'(MAX_HEIGHT);
    end else begin
      clamp_h = RW'(cfg_data);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_w <= CW'(W_RESET);
      frame_h <= RW'(H_RESET);
    end else if (cfg_we) begin
      unique case (cfg_index)
        glmd_pkg::REG_FRAME_WIDTH:  frame_w <= clamp_w;
        glmd_pkg::REG_FRAME_HEIGHT: frame_h <= clamp_h;
      endcase
    end
  end

  // accept stage: position, flags and line memory reads
  assign samples.ready = room;
  assign accept        = samples.valid && samples.ready;

  // a size change that leaves the position outside restarts the frame
  assign wrap    = (col_count >= frame_w) || (row_count >= frame_h);
  assign cur_c   = wrap ? '0 : col_count;
  assign cur_r   = wrap ? '0 : row_count;
  assign c_next  = cur_c + CW'(1);
  assign r_next  = cur_r + RW'(1);
  assign end_col = (c_next >= frame_w);
  assign end_row = (r_next >= frame_h);

  // second read port looks one column ahead for the right neighbour
  assign addr_a = AW'(cur_c);
  assign addr_b = (c_next >= CW'(MAX_WIDTH)) ? AW'(cur_c) : AW'(c_next);

  always_comb begin
    flags.first     = (cur_r == '0) && (cur_c == '0);
    flags.r_ge1     = (cur_r != '0);
    flags.r_ge2     = (cur_r > RW'(1));
    flags.c_ge1     = (cur_c != '0);
    flags.c_ge2     = (cur_c > CW'(1));
    flags.has_right = !end_col;
    flags.last_row  = end_row;
    flags.last_col  = end_col;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
      s1_valid  <= 1'b0;
    end else begin
      s1_valid <= accept;
      if (accept) begin
        if (end_col) begin
          col_count <= '0;
          row_count <= end_row ? '0 : r_next;
        end else begin
          col_count <= c_next;
          row_count <= cur_r;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_x <= HB'(samples.payload.height & IN_MASK);
      s1_r <= cur_r;
      s1_c <= cur_c;
      s1_f <= flags;
    end
  end

  // line memory with write-to-read forwarding across a row boundary
  assign mem_we = s1_valid;
  assign mem_wa = AW'(s1_c);
  assign mem_wd = {s1_x, above_v};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      line_mem[mem_wa] <= mem_wd;
    end
    rd_a  <= line_mem[addr_a];
    rd_b  <= line_mem[addr_b];
    fwd_a <= mem_we && (mem_wa == addr_a);
    fwd_b <= mem_we && (mem_wa == addr_b);
    wd_q  <= mem_wd;
  end

  assign ent_a   = fwd_a ? wd_q : rd_a;
  assign ent_b   = fwd_b ? wd_q : rd_b;
  assign above_v = ent_a[2*HB-1:HB];
  assign up_v    = ent_a[HB-1:0];
  assign right_v = ent_b[2*HB-1:HB];

  // compare stage: cell above, cell to the left on the last row, the corner
  assign above_low = (s1_x > above_v)
                  && !(s1_f.r_ge2 && up_v <= above_v)
                  && !(s1_f.c_ge1 && prev_above <= above_v)
                  && !(s1_f.has_right && right_v <= above_v);

  assign left_low = (s1_x > prev_x)
                 && !(s1_f.r_ge1 && prev_above <= prev_x)
                 && !(s1_f.c_ge2 && prev_x2 <= prev_x);

  assign corner_low = !(s1_f.r_ge1 && above_v <= s1_x)
                   && !(s1_f.c_ge1 && prev_x <= s1_x);

  always_comb begin
    logic [glmd_pkg::SLOT_BITS-1:0] n;
    n                 = '0;
    push.bundle       = '0;
    push.bundle.clear = s1_f.first || clear_pending;
    if (s1_f.r_ge1) begin
      push.bundle.slot[n] = make_result(glmd_pkg::POS_BITS'(s1_r - RW'(1)),
                                        glmd_pkg::POS_BITS'(s1_c),
                                        above_v, above_low, 1'b0);
      n = n + glmd_pkg::SLOT_BITS'(1);
    end
    if (s1_f.last_row && s1_f.c_ge1) begin
      push.bundle.slot[n] = make_result(glmd_pkg::POS_BITS'(s1_r),
                                        glmd_pkg::POS_BITS'(s1_c - CW'(1)),
                                        prev_x, left_low, 1'b0);
      n = n + glmd_pkg::SLOT_BITS'(1);
    end
    if (s1_f.last_row && s1_f.last_col) begin
      push.bundle.slot[n] = make_result(glmd_pkg::POS_BITS'(s1_r),
                                        glmd_pkg::POS_BITS'(s1_c),
                                        s1_x, corner_low, 1'b1);
      n = n + glmd_pkg::SLOT_BITS'(1);
    end
    push.bundle.count = n;
    push.valid        = s1_valid && (n != '0);
  end

  // a frame start with no result of its own marks the next bundle
  always_ff @(posedge clk) begin
    if (rst) begin
      clear_pending <= 1'b0;
    end else if (s1_valid) begin
      clear_pending <= (s1_f.first || clear_pending) && !push.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      prev_x2    <= prev_x;
      prev_x     <= s1_x;
      prev_above <= above_v;
    end
  end

  glmd_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .decisions (decisions)
  );

endmodule

[rtl/glmd_checker.sv]
// port-level assertions for the detector and their bind to the top level
module glmd_checker (
  input logic                clk,
  input logic                rst,
  input logic                out_valid,
  input logic                out_ready,
  input glmd_pkg::decision_t out_data
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result request raised right after reset");

  a_valid_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("stalled result request dropped");

  a_data_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("stalled result payload changed");

  a_done_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.frame_done |-> out_data.last_of_run)
    else $error("frame corner result not last of its run");

  a_risk_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_data.is_low == (out_data.risk != '0)))
    else $error("risk disagrees with minimum flag");

endmodule

bind grid_local_minimum_detect glmd_checker u_glmd_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (decisions.valid),
  .out_ready (decisions.ready),
  .out_data  (decisions.payload)
);
